FILE: rtl/mf3_pkg.sv
// Package for the 3x3 median filter: field widths, register map and the
// small compare functions used by the median stages.
// No dependencies.
package mf3_pkg;

    // Field widths
    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 13;
    localparam int CFG_HEIGHT_W = 16;
    localparam int COL_OUT_W    = 12;
    localparam int ROW_W        = 16;

    // Configuration port
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_LSB  = 2;

    typedef logic [APB_ADDR_W-REG_IDX_LSB-1:0] t_reg_idx;
    localparam t_reg_idx REG_IMAGE_WIDTH  = t_reg_idx'(0);
    localparam t_reg_idx REG_IMAGE_HEIGHT = t_reg_idx'(1);

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = CFG_HEIGHT_W'(480);

    // Smallest frame side; also the first column/row that completes a window
    localparam int MIN_SIZE = 3;
    localparam int WIN_EDGE = 2;
    localparam int WIN_DIM  = 3;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel lo;
        t_pixel md;
        t_pixel hi;
    } t_trio;

    function automatic t_pixel min2(input t_pixel a, input t_pixel b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_pixel max2(input t_pixel a, input t_pixel b);
        return (b < a) ? a : b;
    endfunction

    function automatic t_pixel min3(input t_pixel a, input t_pixel b, input t_pixel c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pixel max3(input t_pixel a, input t_pixel b, input t_pixel c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pixel med3(input t_pixel a, input t_pixel b, input t_pixel c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sorts three pixels into low, middle and high
    function automatic t_trio sort3(input t_pixel a, input t_pixel b, input t_pixel c);
        t_trio r;
        r.lo = min3(a, b, c);
        r.hi = max3(a, b, c);
        r.md = med3(a, b, c);
        return r;
    endfunction

endpackage

FILE: rtl/mf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/median_filter_3x3.sv
// Top level of the 3x3 grayscale median filter.
// Depends on mf3_pkg (types, register map, compare functions) and mf3_ram.
//
// The filter takes one 8-bit pixel per transfer in raster order and keeps
// up with one pixel per clock for as long as the result side takes its
// transfers. Each pixel that completes its window passes in order through
// the registered line store read, the window shift and per-column sort,
// and the final median of medians into the output register. Pixels on the
// left two columns and top two rows of a frame complete no window and
// give no result; every other pixel gives the median of the 3x3
// neighborhood centered one column left and one row up,
// with that center's column and row and a flag on the last result of the
// frame. The two line stores are MAX_WIDTH x 8 RAMs with no clearing pass:
// the filter accepts pixels right out of reset. Image width and height are
// written over the APB port while the filter is idle; widths below 3 act as
// 3, widths above MAX_WIDTH as MAX_WIDTH, heights below 3 as 3.
module median_filter_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mf3_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mf3_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mf3_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Pixel input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mf3_pkg::PIX_W-1:0]         i_pixel,
    // Result output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mf3_pkg::PIX_W-1:0]         o_median,
    output logic [mf3_pkg::COL_OUT_W-1:0]     o_center_column,
    output logic [mf3_pkg::ROW_W-1:0]         o_center_row,
    output logic                              o_frame_last
);
    import mf3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    // Wide enough for the width register and for MAX_WIDTH itself
    localparam int WW = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;
    localparam logic [WW-1:0]    MAX_W    = WW'(MAX_WIDTH);
    localparam logic [WW-1:0]    MIN_W    = WW'(MIN_SIZE);
    localparam logic [ROW_W-1:0] MIN_H    = ROW_W'(MIN_SIZE);
    localparam logic [CW-1:0]    EDGE_X   = CW'(WIN_EDGE);
    localparam logic [ROW_W-1:0] EDGE_Y   = ROW_W'(WIN_EDGE);

    //--------------------------------------------------------------------
    // Configuration registers
    //--------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  r_image_width;
    logic [CFG_HEIGHT_W-1:0] r_image_height;
    logic                    cfg_wr;
    t_reg_idx                reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // Clamp the frame size to what the line stores and window support
    logic [WW-1:0]    wide_w;
    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;

    assign wide_w = WW'(r_image_width);
    assign eff_w  = (wide_w < MIN_W) ? MIN_W : ((wide_w > MAX_W) ? MAX_W : wide_w);
    assign eff_h  = (ROW_W'(r_image_height) < MIN_H) ? MIN_H : ROW_W'(r_image_height);

    //--------------------------------------------------------------------
    // Handshake enables, back to front so bubbles collapse
    //--------------------------------------------------------------------
    logic r_o_valid;
    logic r_b_valid;
    logic r_b_emit;
    logic r_c_valid;
    logic en_out;     // output register may load
    logic en_c;       // sorted-column stage may load
    logic b_leave;    // stage B item moves on this cycle
    logic en_b;       // stage B may load
    logic accept;

    assign en_out  = !r_o_valid || i_ready;
    assign en_c    = !r_c_valid || en_out;
    assign b_leave = r_b_valid && (!r_b_emit || en_c);
    assign en_b    = !r_b_valid || b_leave;
    assign o_ready = en_b;
    assign accept  = i_valid && o_ready;

    //--------------------------------------------------------------------
    // Column / row counters, advanced on each input transfer
    //--------------------------------------------------------------------
    logic [CW-1:0]    r_x;
    logic [ROW_W-1:0] r_y;
    logic [WW-1:0]    x_inc;
    logic [ROW_W:0]   y_inc;
    logic             row_wrap;
    logic             y_wrap;
    logic [CW-1:0]    n_x;
    logic [ROW_W-1:0] n_y;
    logic             emit;
    logic             last;

    assign x_inc    = WW'(r_x) + WW'(1);
    assign row_wrap = (x_inc >= eff_w);
    assign y_inc    = {1'b0, r_y} + (ROW_W + 1)'(1);
    assign y_wrap   = (y_inc >= {1'b0, eff_h});
    assign emit     = (r_x >= EDGE_X) && (r_y >= EDGE_Y);
    assign last     = (WW'(r_x) == eff_w - WW'(1)) && (r_y == eff_h - ROW_W'(1));

    always_comb begin
        if (row_wrap) begin
            n_x = '0;
            n_y = y_wrap ? '0 : y_inc[ROW_W-1:0];
        end else begin
            n_x = x_inc[CW-1:0];
            // Height shrunk under the counter: start a new frame
            n_y = (r_y >= eff_h) ? '0 : r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    //--------------------------------------------------------------------
    // Stage B: line store data arrives; shift the window, update stores
    //--------------------------------------------------------------------
    t_pixel           r_b_pixel;
    logic [CW-1:0]    r_b_x;
    logic [ROW_W-1:0] r_b_y;
    logic             r_b_last;
    t_pixel           top_q;     // row y-2
    t_pixel           mid_q;     // row y-1

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pixel <= i_pixel;
            r_b_x     <= r_x;
            r_b_y     <= r_y;
            r_b_emit  <= emit;
            r_b_last  <= last;
        end
    end

    // Read both stores at the new column; write back when the item leaves B.
    // Consecutive pixels never share a column, so the read never meets the
    // pending write.
    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_older (
        .i_clk     (i_clk),
        .i_wr_en   (b_leave),
        .i_wr_addr (r_b_x),
        .i_wr_data (mid_q),
        .i_rd_en   (accept),
        .i_rd_addr (r_x),
        .o_rd_data (top_q)
    );

    mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_newer (
        .i_clk     (i_clk),
        .i_wr_en   (b_leave),
        .i_wr_addr (r_b_x),
        .i_wr_data (r_b_pixel),
        .i_rd_en   (accept),
        .i_rd_addr (r_x),
        .o_rd_data (mid_q)
    );

    // Window as three columns, oldest first; rows top, middle, bottom
    t_pixel r_win [WIN_DIM][WIN_DIM];
    t_pixel n_win [WIN_DIM][WIN_DIM];

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2][0] = top_q;
        n_win[2][1] = mid_q;
        n_win[2][2] = r_b_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (b_leave) begin
            r_win <= n_win;
        end
    end

    //--------------------------------------------------------------------
    // Stage C: each window column sorted
    //--------------------------------------------------------------------
    t_trio                r_c_cols [WIN_DIM];
    logic [COL_OUT_W-1:0] r_c_col;
    logic [ROW_W-1:0]     r_c_row;
    logic                 r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= b_leave && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && b_leave && r_b_emit) begin
            for (int k = 0; k < WIN_DIM; k++) begin
                r_c_cols[k] <= sort3(n_win[k][0], n_win[k][1], n_win[k][2]);
            end
            r_c_col  <= COL_OUT_W'(r_b_x - CW'(1));
            r_c_row  <= r_b_y - ROW_W'(1);
            r_c_last <= r_b_last;
        end
    end

    //--------------------------------------------------------------------
    // Output register: median of the column lows' max, the middles' median
    // and the highs' min
    //--------------------------------------------------------------------
    t_pixel               r_median;
    logic [COL_OUT_W-1:0] r_col;
    logic [ROW_W-1:0]     r_row;
    logic                 r_last;
    t_pixel               lo_max;
    t_pixel               md_med;
    t_pixel               hi_min;

    assign lo_max = max3(r_c_cols[0].lo, r_c_cols[1].lo, r_c_cols[2].lo);
    assign md_med = med3(r_c_cols[0].md, r_c_cols[1].md, r_c_cols[2].md);
    assign hi_min = min3(r_c_cols[0].hi, r_c_cols[1].hi, r_c_cols[2].hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_c_valid) begin
            r_median <= med3(lo_max, md_med, hi_min);
            r_col    <= r_c_col;
            r_row    <= r_c_row;
            r_last   <= r_c_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_median        = r_median;
    assign o_center_column = r_col;
    assign o_center_row    = r_row;
    assign o_frame_last    = r_last;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    // A new read never targets the column still waiting to be written back
    a_no_ram_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_b_valid && !b_leave) |-> (r_x != r_b_x))
        else $error("line store read meets pending write");

    // A stalled result-bearing item in stage B blocks the input
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_emit && !en_c) |-> !o_ready)
        else $error("input accepted while stage B is stalled");

    // Results come only from interior centers, so the row is never zero
    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_row != '0))
        else $error("result with border row");

    // Finishing the last row of a frame restarts the counters
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && row_wrap && y_wrap) |=> (r_x == '0) && (r_y == '0))
        else $error("counters did not wrap at end of frame");

    // An item enters stage C only when it gives a result
    a_c_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_c && b_leave && !r_b_emit) |=> !r_c_valid)
        else $error("border pixel reached the sort stage");

endmodule
